// File: rtl/ddm_pkg.sv
package ddm_pkg;

  localparam int ORD_W = 12;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int DIV_STEPS = 49;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_READ = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  row_index;
    logic [7:0]  col_index;
    logic [31:0] eig_value;
    logic [31:0] phi_value;
    logic [31:0] dphi_value;
  } in_word_t;

  typedef struct packed {
    logic [31:0] divided_difference;
    logic        saturated;
  } out_word_t;

  typedef struct packed {
    req_kind_t        kind;
    logic [ORD_W-1:0] row;
    logic [ORD_W-1:0] col;
    logic [ORD_W-1:0] hi;
    logic [31:0]      eig;
    logic [31:0]      phi;
    logic [31:0]      dphi;
  } job_t;

  typedef struct packed {
    logic        start;
    logic [48:0] dividend;
    logic [32:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [48:0] quotient;
  } div_rsp_t;

endpackage

// File: rtl/ddm_front.sv
module ddm_front #(
  parameter int MAX_ORDER = 256
) (
  input  ddm_pkg::in_word_t req,
  input  logic              req_valid,
  output logic              req_ready,
  output ddm_pkg::job_t     job,
  output logic              push,
  input  logic              q_full
);
  import ddm_pkg::*;

  function automatic logic [ORD_W-1:0] wrap(input logic [7:0] v);
    logic [15:0] t;
    t = {8'd0, v};
    if (MAX_ORDER < 256) begin
      for (int k = 7; k >= 0; k--) begin
        if (t >= (16'(MAX_ORDER) << k)) t = t - (16'(MAX_ORDER) << k);
      end
    end
    return t[ORD_W-1:0];
  endfunction

  logic [ORD_W-1:0] row_w;
  logic [ORD_W-1:0] col_w;

  assign row_w = wrap(req.row_index);
  assign col_w = wrap(req.col_index);

  assign req_ready = !q_full;
  assign push      = req_valid && !q_full;

  always_comb begin
    job.kind = (req.req_type == 1'b1) ? REQ_READ : REQ_LOAD;
    job.row  = row_w;
    job.col  = col_w;
    job.hi   = (row_w > col_w) ? row_w : col_w;
    job.eig  = req.eig_value;
    job.phi  = req.phi_value;
    job.dphi = req.dphi_value;
  end

endmodule

// File: rtl/ddm_queue.sv
module ddm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ddm_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output ddm_pkg::job_t head,
  output logic          nonempty
);
  import ddm_pkg::*;

  job_t               slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_PTR_W:0]   count;

  assign full     = (count == (Q_PTR_W+1)'(Q_DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// File: rtl/ddm_div.sv
module ddm_div (
  input  logic              clk,
  input  logic              rst,
  input  ddm_pkg::div_req_t dreq,
  output ddm_pkg::div_rsp_t drsp
);
  import ddm_pkg::*;

  logic [32:0]          rem;
  logic [48:0]          quo;
  logic [32:0]          dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [33:0]          shifted;
  logic [33:0]          trial;

  assign shifted = {rem, quo[48]};
  assign trial   = shifted - {1'b0, dvs};

  assign drsp.quotient = quo;
  assign drsp.done     = done;

  always_ff @(posedge clk) begin
    if (dreq.start) begin
      rem <= '0;
      quo <= dreq.dividend;
      dvs <= dreq.divisor;
    end else if (busy) begin
      if (!trial[33]) begin
        rem <= trial[32:0];
        quo <= {quo[47:0], 1'b1};
      end else begin
        rem <= shifted[32:0];
        quo <= {quo[47:0], 1'b0};
      end
    end
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (dreq.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/ddm_back.sv
module ddm_back #(
  parameter int MAX_ORDER = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [30:0]        tie_tolerance,
  input  ddm_pkg::job_t      head,
  input  logic               nonempty,
  output logic               pop,
  output ddm_pkg::div_req_t  dreq,
  input  ddm_pkg::div_rsp_t  drsp,
  output ddm_pkg::out_word_t rsp,
  output logic               rsp_valid,
  input  logic               rsp_ready
);
  import ddm_pkg::*;

  localparam int IDX_W = $clog2(MAX_ORDER);

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIFF,
    B_MAG,
    B_DECIDE,
    B_DIV,
    B_DONE
  } state_t;

  state_t      state;
  logic [31:0] eig_mem  [MAX_ORDER];
  logic [31:0] phi_mem  [MAX_ORDER];
  logic [31:0] dphi_mem [MAX_ORDER];

  logic [31:0] eig_i, eig_j, phi_i, phi_j, dphi_k;
  logic [32:0] dd, pd;
  logic [32:0] dmag;
  logic [48:0] nmag;
  logic        neg;
  logic [31:0] res;
  logic        res_sat;
  logic [IDX_W-1:0] ri, rj, rk;

  assign ri  = head.row[IDX_W-1:0];
  assign rj  = head.col[IDX_W-1:0];
  assign rk  = head.hi[IDX_W-1:0];
  assign pop = (state == B_IDLE) && nonempty;

  assign dreq.dividend = nmag;
  assign dreq.divisor  = dmag;
  assign dreq.start    = (state == B_DECIDE) && (dmag > {2'b00, tie_tolerance});

  always_ff @(posedge clk) begin
    if (pop) begin
      unique case (head.kind)
        REQ_LOAD: begin
          eig_mem[ri]  <= head.eig;
          phi_mem[ri]  <= head.phi;
          dphi_mem[ri] <= head.dphi;
        end
        REQ_READ: begin
          eig_i  <= eig_mem[ri];
          eig_j  <= eig_mem[rj];
          phi_i  <= phi_mem[ri];
          phi_j  <= phi_mem[rj];
          dphi_k <= dphi_mem[rk];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_ready && state != B_DONE) rsp_valid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (pop && head.kind == REQ_READ) state <= B_DIFF;
        end
        B_DIFF: begin
          dd    <= {eig_i[31], eig_i} - {eig_j[31], eig_j};
          pd    <= {phi_i[31], phi_i} - {phi_j[31], phi_j};
          state <= B_MAG;
        end
        B_MAG: begin
          dmag  <= dd[32] ? (~dd + 33'd1) : dd;
          nmag  <= {(pd[32] ? (~pd + 33'd1) : pd), 16'd0};
          neg   <= dd[32] ^ pd[32];
          state <= B_DECIDE;
        end
        B_DECIDE: begin
          if (dreq.start) begin
            state <= B_DIV;
          end else begin
            res     <= dphi_k;
            res_sat <= 1'b0;
            state   <= B_DONE;
          end
        end
        B_DIV: begin
          if (drsp.done) begin
            if (neg) begin
              if (drsp.quotient > 49'h0_8000_0000) begin
                res     <= 32'h8000_0000;
                res_sat <= 1'b1;
              end else begin
                res     <= ~drsp.quotient[31:0] + 32'd1;
                res_sat <= 1'b0;
              end
            end else begin
              if (drsp.quotient[48:31] != '0) begin
                res     <= 32'h7FFF_FFFF;
                res_sat <= 1'b1;
              end else begin
                res     <= drsp.quotient[31:0];
                res_sat <= 1'b0;
              end
            end
            state <= B_DONE;
          end
        end
        B_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp.divided_difference <= res;
            rsp.saturated          <= res_sat;
            rsp_valid              <= 1'b1;
            state                  <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/divided_difference_matrix.sv
// Load word: leaves the queue when the back end is idle and is written as it leaves;
// loads pass at one word per cycle while no read is in the back end.
// Read word: on a tie the result is the stored derivative, otherwise it passes through the
// 49-step radix-2 divider; the back end takes no new word until that result is registered.
// A four-word queue lets the input side run ahead of the back end.
// Synchronous active-high reset clears control state and the tolerance (to zero);
// the element stores hold no reset value and need no clearing pass.
module divided_difference_matrix #(
  parameter int MAX_ORDER = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  ddm_pkg::in_word_t  req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output ddm_pkg::out_word_t rsp,
  input  logic               cfg_we,
  input  logic [30:0]        cfg_wdata
);
  import ddm_pkg::*;

  logic [30:0] tie_tolerance;
  job_t        push_job;
  job_t        head;
  logic        push, full, pop, nonempty;
  div_req_t    dreq;
  div_rsp_t    drsp;

  always_ff @(posedge clk) begin
    if (rst)         tie_tolerance <= '0;
    else if (cfg_we) tie_tolerance <= cfg_wdata;
  end

  ddm_front #(.MAX_ORDER(MAX_ORDER)) u_front (
    .req       (req),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .job       (push_job),
    .push      (push),
    .q_full    (full)
  );

  ddm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .nonempty (nonempty)
  );

  ddm_div u_div (
    .clk  (clk),
    .rst  (rst),
    .dreq (dreq),
    .drsp (drsp)
  );

  ddm_back #(.MAX_ORDER(MAX_ORDER)) u_back (
    .clk           (clk),
    .rst           (rst),
    .tie_tolerance (tie_tolerance),
    .head          (head),
    .nonempty      (nonempty),
    .pop           (pop),
    .dreq          (dreq),
    .drsp          (drsp),
    .rsp           (rsp),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready)
  );

endmodule

// File: rtl/ddm_checker.sv
module ddm_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input ddm_pkg::in_word_t  req,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input ddm_pkg::out_word_t rsp
);
  import ddm_pkg::*;

  logic [3:0] pending;
  logic       rd_in, rd_out;

  assign rd_in  = req_valid && req_ready && req.req_type;
  assign rd_out = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) pending <= '0;
    else if (rd_in && !rd_out) pending <= pending + 1'b1;
    else if (rd_out && !rd_in) pending <= pending - 1'b1;
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result word dropped or changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.saturated |->
      (rsp.divided_difference == 32'h7FFF_FFFF || rsp.divided_difference == 32'h8000_0000))
    else $error("saturated flag without a clipped value");

  a_owed: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != '0)
    else $error("result word without an outstanding read");

endmodule

bind divided_difference_matrix ddm_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ddm_pkg::*;

  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES = 64;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_WORDS = 365;

  class entry_scoreboard;
    logic signed [31:0] eig_of [256];
    logic signed [31:0] phi_of [256];
    logic signed [31:0] dphi_of [256];
    logic [30:0] tie_limit;
    out_word_t expected_entries [$];
    int failures;

    function new();
      tie_limit = '0;
      failures = 0;
    endfunction

    function out_word_t divided_entry(logic [7:0] row, logic [7:0] col);
      longint eig_gap, phi_gap;
      longint unsigned gap_mag, num_mag, quo;
      out_word_t entry;
      entry.saturated = 1'b0;
      eig_gap = longint'(eig_of[row]) - longint'(eig_of[col]);
      gap_mag = (eig_gap < 0) ? -eig_gap : eig_gap;
      if (gap_mag > tie_limit) begin
        phi_gap = longint'(phi_of[row]) - longint'(phi_of[col]);
        num_mag = (phi_gap < 0) ? -phi_gap : phi_gap;
        num_mag = num_mag << 16;
        quo = num_mag / gap_mag;
        if ((phi_gap < 0) != (eig_gap < 0)) begin
          if (quo > 64'h8000_0000) begin
            quo = 64'h8000_0000;
            entry.saturated = 1'b1;
          end
          entry.divided_difference = -quo[31:0];
        end else begin
          if (quo > 64'h7FFF_FFFF) begin
            quo = 64'h7FFF_FFFF;
            entry.saturated = 1'b1;
          end
          entry.divided_difference = quo[31:0];
        end
      end else begin
        // tie: derivative at the larger index
        entry.divided_difference = dphi_of[(row > col) ? row : col];
      end
      return entry;
    endfunction

    function void note_word(in_word_t word);
      if (word.req_type == REQ_LOAD) begin
        eig_of[word.row_index] = word.eig_value;
        phi_of[word.row_index] = word.phi_value;
        dphi_of[word.row_index] = word.dphi_value;
      end else begin
        expected_entries.push_back(divided_entry(word.row_index, word.col_index));
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (expected_entries.size() == 0) begin
        $error("unexpected result word: divided_difference %h saturated %b",
               got.divided_difference, got.saturated);
        failures++;
        return;
      end
      want = expected_entries.pop_front();
      if (got.divided_difference !== want.divided_difference) begin
        $error("divided_difference: expected %h, actual %h",
               want.divided_difference, got.divided_difference);
        failures++;
      end
      if (got.saturated !== want.saturated) begin
        $error("saturated: expected %b, actual %b", want.saturated, got.saturated);
        failures++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  in_word_t    req;
  logic        rsp_valid;
  logic        rsp_ready;
  out_word_t   rsp;
  logic        cfg_we;
  logic [30:0] cfg_wdata;

  entry_scoreboard book = new();
  bit          steady;
  bit          stall_request;
  int          idle_cycles;
  int          words_sent;
  bit          loaded [256];
  logic [7:0]  loaded_ids [$];

  divided_difference_matrix #(.MAX_ORDER(256)) DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request) begin
        rsp_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        stall_request = 1'b0;
      end else begin
        rsp_ready <= steady || ($urandom_range(0, 99) >= 31);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) book.check_word(rsp);
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic in_word_t load_word(logic [7:0] idx, logic [31:0] eig,
                                         logic [31:0] phi, logic [31:0] dphi);
    in_word_t word;
    word.req_type = REQ_LOAD;
    word.row_index = idx;
    word.col_index = 8'($urandom);
    word.eig_value = eig;
    word.phi_value = phi;
    word.dphi_value = dphi;
    if (!loaded[idx]) begin
      loaded[idx] = 1'b1;
      loaded_ids.push_back(idx);
    end
    return word;
  endfunction

  function automatic in_word_t read_word(logic [7:0] row, logic [7:0] col);
    in_word_t word;
    word.req_type = REQ_READ;
    word.row_index = row;
    word.col_index = col;
    word.eig_value = $urandom;
    word.phi_value = $urandom;
    word.dphi_value = $urandom;
    return word;
  endfunction

  function automatic in_word_t random_word();
    logic [7:0]  idx, row, col, near;
    logic [31:0] eig, phi, span;
    int unsigned pick;
    idx = 8'($urandom);
    near = loaded_ids[$urandom_range(0, loaded_ids.size() - 1)];
    if ($urandom_range(0, 99) < 35) begin
      // eigenvalues clustered around stored ones to hit ties and tolerance edges
      pick = $urandom_range(0, 9);
      span = 32'(book.tie_limit);
      if (pick < 3) eig = book.eig_of[near] + 32'($urandom_range(0, 32)) - 32'd16;
      else if (pick < 5) eig = book.eig_of[near] + ($urandom_range(0, 1) ? span : -span)
                               + 32'($urandom_range(0, 2)) - 32'd1;
      else if (pick < 7) eig = 32'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
      else eig = $urandom;
      pick = $urandom_range(0, 9);
      if (pick < 3) phi = book.phi_of[near] + 32'($urandom_range(0, 2048)) - 32'd1024;
      else if (pick < 4) phi = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      else phi = $urandom;
      return load_word(idx, eig, phi, $urandom);
    end
    row = near;
    col = ($urandom_range(0, 9) == 0) ? row
          : loaded_ids[$urandom_range(0, loaded_ids.size() - 1)];
    return read_word(row, col);
  endfunction

  // entered and left just after a falling edge
  task automatic send_word(in_word_t word);
    while (!steady && $urandom_range(0, 99) < 31) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req <= word;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    book.note_word(word);
    @(negedge clk);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (book.expected_entries.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_tolerance(logic [30:0] value);
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    book.tie_limit = value;
  endtask

  task automatic run_phase(logic [30:0] tolerance);
    drain();
    set_tolerance(tolerance);
    for (int n = 0; n < PHASE_WORDS; n++) begin
      steady = (words_sent >= 700 && words_sent < 1000);
      if (words_sent == 300) stall_request = 1'b1;
      if (words_sent == 1200) drain();
      send_word(random_word());
      words_sent++;
    end
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    steady = 1'b0;
    stall_request = 1'b0;
    words_sent = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    set_tolerance('0);

    send_word(load_word(8'd0, 32'h0000_0000, 32'h7FFF_FFFF, 32'h1234_5678));
    send_word(load_word(8'd255, 32'h0000_0001, 32'h8000_0000, 32'h8000_0000));
    send_word(load_word(8'd1, 32'h7FFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF));
    send_word(load_word(8'd2, 32'h8000_0000, 32'h0001_0000, 32'hFFFF_FFFF));
    send_word(load_word(8'd3, 32'h0000_0000, 32'h0000_0005, 32'h0000_ABCD));
    send_word(load_word(8'd6, 32'h0000_0010, 32'h0000_0000, 32'h0000_0001));
    send_word(load_word(8'd7, 32'h0000_0011, 32'hFFFF_8000, 32'h0000_0002));
    send_word(load_word(8'd9, 32'h0000_0013, 32'h7FFF_FFFF, 32'h0000_0003));
    send_word(read_word(8'd0, 8'd255));   // negative overflow
    send_word(read_word(8'd255, 8'd0));
    send_word(read_word(8'd7, 8'd6));     // exactly -2^31, no clip
    send_word(read_word(8'd6, 8'd7));
    send_word(read_word(8'd9, 8'd6));     // positive overflow
    send_word(read_word(8'd0, 8'd3));     // equal eigenvalues
    send_word(read_word(8'd3, 8'd0));
    send_word(read_word(8'd0, 8'd0));
    send_word(read_word(8'd255, 8'd255));
    send_word(read_word(8'd1, 8'd2));     // widest eigenvalue gap
    send_word(read_word(8'd0, 8'd2));
    drain();
    set_tolerance(31'h7FFF_FFFF);
    send_word(read_word(8'd0, 8'd255));
    send_word(read_word(8'd0, 8'd1));     // gap equals tolerance
    send_word(read_word(8'd0, 8'd2));     // gap one above tolerance
    send_word(read_word(8'd1, 8'd2));
    drain();
    set_tolerance(31'd1);
    send_word(read_word(8'd6, 8'd7));
    send_word(read_word(8'd9, 8'd6));

    run_phase('0);
    run_phase(31'($urandom_range(1, 64)));
    run_phase(31'h7FFF_FFFF);
    run_phase(31'($urandom));
    run_phase(31'($urandom_range(1 << 12, 1 << 20)));
    drain();

    if (book.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/ddm_pkg.sv
rtl/ddm_front.sv
rtl/ddm_queue.sv
rtl/ddm_div.sv
rtl/ddm_back.sv
rtl/divided_difference_matrix.sv
rtl/ddm_checker.sv
dv/testbench.sv
